### hw/rtl/quantile_energy_threshold_assert.svh
// assertion macros used by the checker file
`ifndef QUANTILE_ENERGY_THRESHOLD_ASSERT_SVH
`define QUANTILE_ENERGY_THRESHOLD_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define QET_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define QET_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/qet_pkg.sv
// shared types and constants of the quantile energy threshold block
package qet_pkg;

    localparam int MAX_ITEMS_DEF = 4096;

    localparam logic [2:0] REG_SELECT_FRACTION = 3'd0;
    localparam logic [2:0] REG_MEDIAN_FACTOR   = 3'd1;
    localparam logic [2:0] REG_CONSTANT_WEIGHT = 3'd2;
    localparam logic [2:0] REG_OVERALL_WEIGHT  = 3'd3;
    localparam logic [2:0] REG_PATTERN_COUNT   = 3'd4;

    localparam logic [15:0] RST_SELECT_FRACTION = 16'd45875;
    localparam logic [15:0] RST_MEDIAN_FACTOR   = 16'd384;
    localparam logic [15:0] RST_CONSTANT_WEIGHT = 16'd32768;
    localparam logic [15:0] RST_OVERALL_WEIGHT  = 16'd256;
    localparam logic [4:0]  RST_PATTERN_COUNT   = 5'd8;

    localparam logic [7:0] FALLBACK_SCALE = 8'd144;
    localparam logic [4:0] BLEND_CONST    = 5'd26;

    localparam int USED_COUNT_W = 13;

    typedef struct packed {
        logic        start;
        logic [31:0] energy;
    } qet_arith_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] threshold;
    } qet_arith_rsp_t;

endpackage

### hw/rtl/qet_arith.sv
// threshold formula: bit-serial square root followed by registered multiplies
module qet_arith (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  qet_pkg::qet_arith_req_t req,
    input  logic [15:0]             median_factor,
    input  logic [15:0]             constant_weight,
    input  logic [15:0]             overall_weight,
    output qet_pkg::qet_arith_rsp_t rsp
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SQRT, ST_MUL_M, ST_MUL_T, ST_MUL_U, ST_SQUARE, ST_ROUND
    } state_t;

    state_t      state_reg;
    logic [47:0] v_reg;
    logic [25:0] rem_reg;
    logic [23:0] root_reg;
    logic [4:0]  step_reg;
    logic [39:0] m_reg;
    logic [57:0] t_reg;
    logic [49:0] p_reg;
    logic [63:0] sq_reg;
    logic        sat_reg;
    logic        done_reg;
    logic [31:0] th_reg;

    logic [25:0] rem_sh;
    logic [25:0] trial;
    logic [16:0] cw_inv;
    logic [20:0] cw26;
    logic [56:0] mt;
    logic [57:0] t_rnd;
    logic [33:0] t16;
    logic [49:0] u_rnd;
    logic [41:0] u16;
    logic [64:0] sq_rnd;
    logic [48:0] th_full;

    always_comb begin
        rem_sh  = {rem_reg[23:0], v_reg[47:46]};
        trial   = {root_reg, 2'b01};
        cw_inv  = 17'h10000 - 17'(constant_weight);
        cw26    = 21'(constant_weight) * 21'(qet_pkg::BLEND_CONST);
        mt      = 57'(m_reg) * 57'(cw_inv);
        t_rnd   = t_reg + 58'h800000;
        t16     = t_rnd[57:24];
        u_rnd   = p_reg + 50'd128;
        u16     = u_rnd[49:8];
        sq_rnd  = 65'(sq_reg) + 65'd32768;
        th_full = sq_rnd[64:16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (req.start) begin
                        v_reg     <= {req.energy, 16'd0};
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        step_reg  <= 5'd23;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (rem_sh >= trial) begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[22:0], 1'b1};
                    end else begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[22:0], 1'b0};
                    end
                    v_reg    <= {v_reg[45:0], 2'b00};
                    step_reg <= step_reg - 5'd1;
                    if (step_reg == 5'd0) begin
                        state_reg <= ST_MUL_M;
                    end
                end
                ST_MUL_M: begin
                    m_reg     <= 40'(root_reg) * 40'(median_factor);
                    state_reg <= ST_MUL_T;
                end
                ST_MUL_T: begin
                    t_reg     <= {13'd0, cw26, 24'd0} + 58'(mt);
                    state_reg <= ST_MUL_U;
                end
                ST_MUL_U: begin
                    p_reg     <= 50'(t16) * 50'(overall_weight);
                    state_reg <= ST_SQUARE;
                end
                ST_SQUARE: begin
                    sat_reg   <= |u16[41:32];
                    sq_reg    <= 64'(u16[31:0]) * 64'(u16[31:0]);
                    state_reg <= ST_ROUND;
                end
                ST_ROUND: begin
                    th_reg    <= (sat_reg || (|th_full[48:32])) ? 32'hFFFF_FFFF : th_full[31:0];
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.threshold = th_reg;

endmodule

### hw/rtl/quantile_energy_threshold.sv
// Quantile energy threshold: energies are stored at one per cycle while a batch
// loads (s_ready high). After the transaction marked last, the block selects
// the k-th smallest stored energy by a 32-step binary search over the value
// range; each step sweeps the n stored entries through the single read port of
// the energy memory, and the selection is followed by a bit-serial square root
// and registered multiplies. An empty batch returns its fallback result. s_ready
// is low from the last transaction until the result is registered. No clearing
// pass runs.
module quantile_energy_threshold #(
    parameter int MAX_ITEMS = qet_pkg::MAX_ITEMS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_energy,
    input  logic        s_energy_valid,
    input  logic        s_targets_new,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_threshold,
    output logic [12:0] m_used_count,
    output logic        m_fallback
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    typedef enum logic [2:0] {
        ST_LOAD, ST_KINIT, ST_BSTART, ST_SCAN, ST_EVAL, ST_ARITH, ST_OUT
    } state_t;

    logic [15:0] frac_reg, fac_reg, cw_reg, ow_reg;
    logic [4:0]  pc_reg;

    state_t      state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] c_reg, c_next;
    logic [31:0] lo_reg, lo_next;
    logic [31:0] hi_reg, hi_next;
    logic [31:0] mid_reg, mid_next;
    logic [31:0] th_reg, th_next;
    logic        fb_reg, fb_next;
    logic        rv_reg;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_threshold_reg, m_threshold_next;
    logic [12:0] m_used_count_reg, m_used_count_next;
    logic        m_fallback_reg, m_fallback_next;

    logic [31:0] mem [MAX_ITEMS];
    logic [31:0] rdata_reg;

    logic        s_accept, qual, wr_en, rd_en, cfg_wr;
    logic [CW+15:0] kprod;
    logic [32:0] lohi;
    qet_pkg::qet_arith_req_t arith_req;
    qet_pkg::qet_arith_rsp_t arith_rsp;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_ready  = (state_reg == ST_LOAD);
    assign s_accept = s_valid && s_ready;
    assign qual     = s_energy_valid && s_targets_new && (count_reg < CW'(MAX_ITEMS));
    assign wr_en    = s_accept && qual;
    assign rd_en    = (state_reg == ST_SCAN) && (idx_reg < n_reg);
    assign kprod    = (CW+16)'(frac_reg) * (CW+16)'(n_reg);
    assign lohi     = 33'(lo_reg) + 33'(hi_reg);

    always_comb begin
        case (paddr[4:2])
            qet_pkg::REG_SELECT_FRACTION: prdata = 32'(frac_reg);
            qet_pkg::REG_MEDIAN_FACTOR:   prdata = 32'(fac_reg);
            qet_pkg::REG_CONSTANT_WEIGHT: prdata = 32'(cw_reg);
            qet_pkg::REG_OVERALL_WEIGHT:  prdata = 32'(ow_reg);
            qet_pkg::REG_PATTERN_COUNT:   prdata = 32'(pc_reg);
            default:                      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frac_reg <= qet_pkg::RST_SELECT_FRACTION;
            fac_reg  <= qet_pkg::RST_MEDIAN_FACTOR;
            cw_reg   <= qet_pkg::RST_CONSTANT_WEIGHT;
            ow_reg   <= qet_pkg::RST_OVERALL_WEIGHT;
            pc_reg   <= qet_pkg::RST_PATTERN_COUNT;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                qet_pkg::REG_SELECT_FRACTION: frac_reg <= pwdata[15:0];
                qet_pkg::REG_MEDIAN_FACTOR:   fac_reg  <= pwdata[15:0];
                qet_pkg::REG_CONSTANT_WEIGHT: cw_reg   <= pwdata[15:0];
                qet_pkg::REG_OVERALL_WEIGHT:  ow_reg   <= pwdata[15:0];
                qet_pkg::REG_PATTERN_COUNT:   pc_reg   <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[AW-1:0]] <= s_energy;
        end
        if (rd_en) begin
            rdata_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    always_comb begin
        state_next        = state_reg;
        count_next        = count_reg;
        n_next            = n_reg;
        k_next            = k_reg;
        idx_next          = idx_reg;
        c_next            = c_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        mid_next          = mid_reg;
        th_next           = th_reg;
        fb_next           = fb_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_threshold_next  = m_threshold_reg;
        m_used_count_next = m_used_count_reg;
        m_fallback_next   = m_fallback_reg;
        arith_req.start   = 1'b0;
        arith_req.energy  = lo_reg;
        case (state_reg)
            ST_LOAD: begin
                if (wr_en) begin
                    count_next = count_reg + CW'(1);
                end
                if (s_accept && s_last) begin
                    n_next     = count_reg + CW'(wr_en);
                    count_next = '0;
                    state_next = ST_KINIT;
                end
            end
            ST_KINIT: begin
                if (n_reg == '0) begin
                    th_next    = {16'(qet_pkg::FALLBACK_SCALE) * 16'(pc_reg), 16'd0};
                    fb_next    = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    k_next     = kprod[CW+15:16];
                    lo_next    = '0;
                    hi_next    = 32'hFFFF_FFFF;
                    state_next = ST_BSTART;
                end
            end
            ST_BSTART: begin
                if (lo_reg < hi_reg) begin
                    mid_next   = lohi[32:1];
                    idx_next   = '0;
                    c_next     = '0;
                    state_next = ST_SCAN;
                end else begin
                    arith_req.start = 1'b1;
                    state_next      = ST_ARITH;
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    idx_next = idx_reg + CW'(1);
                end
                if (rv_reg && (rdata_reg <= mid_reg)) begin
                    c_next = c_reg + CW'(1);
                end
                if (!rd_en && !rv_reg) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (c_reg > k_reg) begin
                    hi_next = mid_reg;
                end else begin
                    lo_next = mid_reg + 32'd1;
                end
                state_next = ST_BSTART;
            end
            ST_ARITH: begin
                if (arith_rsp.done) begin
                    th_next    = arith_rsp.threshold;
                    fb_next    = 1'b0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_threshold_next  = th_reg;
                    m_used_count_next = 13'(n_reg);
                    m_fallback_next   = fb_reg;
                    state_next        = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            rv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rv_reg      <= rd_en;
            m_valid_reg <= m_valid_next;
        end
        n_reg            <= n_next;
        k_reg            <= k_next;
        idx_reg          <= idx_next;
        c_reg            <= c_next;
        lo_reg           <= lo_next;
        hi_reg           <= hi_next;
        mid_reg          <= mid_next;
        th_reg           <= th_next;
        fb_reg           <= fb_next;
        m_threshold_reg  <= m_threshold_next;
        m_used_count_reg <= m_used_count_next;
        m_fallback_reg   <= m_fallback_next;
    end

    qet_arith u_arith (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .req             (arith_req),
        .median_factor   (fac_reg),
        .constant_weight (cw_reg),
        .overall_weight  (ow_reg),
        .rsp             (arith_rsp)
    );

    assign m_valid      = m_valid_reg;
    assign m_threshold  = m_threshold_reg;
    assign m_used_count = m_used_count_reg;
    assign m_fallback   = m_fallback_reg;

endmodule

### hw/rtl/qet_checker.sv
// port-level checker for the quantile energy threshold block, with its bind
`include "quantile_energy_threshold_assert.svh"

module qet_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        pready,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_last,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_threshold,
    input logic [12:0] m_used_count,
    input logic        m_fallback
);

    // a waiting result holds its value
    `QET_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_threshold))

    // a last transaction closes the batch and stalls input during selection
    `QET_ASSERT_NEXT(a_last_stall, s_valid && s_ready && s_last, !s_ready)

    // fallback result is an integer threshold with nothing counted
    `QET_ASSERT_SAME(a_fb_shape, m_valid && m_fallback,
                     m_used_count == 13'd0 && m_threshold[15:0] == 16'd0)

    `QET_ASSERT_SAME(a_pready, 1'b1, pready)

endmodule

bind quantile_energy_threshold qet_checker u_qet_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .pready       (pready),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_last       (s_last),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_threshold  (m_threshold),
    .m_used_count (m_used_count),
    .m_fallback   (m_fallback)
);

### test/quantile_energy_threshold_tb.sv
// self-checking testbench for the quantile energy threshold block
module quantile_energy_threshold_tb;

    typedef struct packed {
        logic [31:0] threshold;
        logic [12:0] used_count;
        logic        fallback;
    } thresh_result_t;

    typedef struct {
        logic [31:0] energy;
        logic        energy_valid;
        logic        targets_new;
        logic        last;
        bit          typed;
        logic [31:0] threshold;
        logic [12:0] used_count;
        logic        fallback;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_energy = '0;
    logic        s_energy_valid = 1'b0;
    logic        s_targets_new = 1'b0;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_threshold;
    logic [12:0] m_used_count;
    logic        m_fallback;

    thresh_result_t pending_thresholds[$];
    logic [31:0]    batch_energies[$];
    logic [15:0]    fraction_q, factor_q, cweight_q, oweight_q;
    logic [4:0]     pat_count_q;
    int             fail_count = 0;
    int             cycle_count = 0;
    int             ready_hold = 0;
    bit             quiet = 0;

    quantile_energy_threshold uut (.*);

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (ready_hold > 0) begin
            ready_hold--;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            ready_hold = $urandom_range(0, 3);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        thresh_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_thresholds.size() == 0) begin
                $error("unexpected transaction threshold=%0h", m_threshold);
                fail_count++;
            end else begin
                want = pending_thresholds.pop_front();
                if (m_threshold !== want.threshold) begin
                    $error("threshold expected %0h actual %0h", want.threshold, m_threshold);
                    fail_count++;
                end
                if (m_used_count !== want.used_count) begin
                    $error("used_count expected %0d actual %0d", want.used_count,
                           m_used_count);
                    fail_count++;
                end
                if (m_fallback !== want.fallback) begin
                    $error("fallback expected %0b actual %0b", want.fallback, m_fallback);
                    fail_count++;
                end
            end
        end
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic thresh_result_t close_batch();
        thresh_result_t res;
        logic [31:0] sorted[$];
        int unsigned n, k;
        logic [127:0] root, t, t16, u16, th;
        n = batch_energies.size();
        if (n == 0) begin
            res.threshold = (32'(qet_pkg::FALLBACK_SCALE) * pat_count_q) << 16;
            res.used_count = '0;
            res.fallback = 1'b1;
        end else begin
            sorted = batch_energies;
            sorted.sort();
            k = (64'(fraction_q) * n) >> 16;
            root = int_sqrt(64'(sorted[k]) << 16);
            t = ((128'(qet_pkg::BLEND_CONST) * cweight_q) << 24)
                + root * factor_q * (128'd65536 - cweight_q);
            t16 = (t + (128'd1 << 23)) >> 24;
            u16 = (t16 * oweight_q + 128) >> 8;
            th = (u16 * u16 + 32768) >> 16;
            res.threshold = (u16 > 128'hFFFFFFFF || th > 128'hFFFFFFFF) ? 32'hFFFFFFFF
                                                                       : th[31:0];
            res.used_count = n[12:0];
            res.fallback = 1'b0;
        end
        batch_energies.delete();
        return res;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            qet_pkg::REG_SELECT_FRACTION: fraction_q = val[15:0];
            qet_pkg::REG_MEDIAN_FACTOR:   factor_q = val[15:0];
            qet_pkg::REG_CONSTANT_WEIGHT: cweight_q = val[15:0];
            qet_pkg::REG_OVERALL_WEIGHT:  oweight_q = val[15:0];
            qet_pkg::REG_PATTERN_COUNT:   pat_count_q = val[4:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_thresholds.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic send(logic [31:0] e, logic ev, logic tn, logic lst, bit typed = 0,
                        thresh_result_t typed_res = '0);
        thresh_result_t res;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_energy <= e;
        s_energy_valid <= ev;
        s_targets_new <= tn;
        s_last <= lst;
        do @(posedge aclk); while (!s_ready);
        if (ev && tn && batch_energies.size() < qet_pkg::MAX_ITEMS_DEF)
            batch_energies.insert(batch_energies.size(), e);
        if (lst) begin
            res = close_batch();
            pending_thresholds.insert(pending_thresholds.size(), typed ? typed_res : res);
        end
    endtask

    task automatic end_stream();
        s_valid <= 1'b0;
        wait_drained();
    endtask

    function automatic logic [31:0] rand_energy();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom >> $urandom_range(0, 31);
            2: return $urandom_range(0, 3) == 0 ? 32'hFFFFFFFF : 32'h0;
            default: return $urandom_range(0, 65535) << 8;
        endcase
    endfunction

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(0, 4))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    stim_row_t directed[] = '{
        '{32'h0, 1, 1, 1, 0, 0, 0, 0},
        '{32'h0, 0, 0, 1, 1, 32'd75497472, 13'd0, 1'b1},
        '{32'h0, 1, 1, 1, 1, 32'd11075584, 13'd1, 1'b0},
        '{32'hFFFFFFFF, 1, 1, 1, 0, 0, 0, 0},
        '{32'h1234, 0, 1, 1, 1, 32'd75497472, 13'd0, 1'b1},
        '{32'h1234, 1, 0, 1, 1, 32'd75497472, 13'd0, 1'b1},
        '{32'h00050000, 1, 1, 0, 0, 0, 0, 0},
        '{32'h00010000, 1, 1, 0, 0, 0, 0, 0},
        '{32'hFFFFFFFF, 0, 1, 0, 0, 0, 0, 0},
        '{32'h00090000, 1, 0, 0, 0, 0, 0, 0},
        '{32'h00030000, 1, 1, 1, 0, 0, 0, 0},
        '{32'h00020000, 1, 1, 0, 0, 0, 0, 0},
        '{32'h00020000, 1, 1, 0, 0, 0, 0, 0},
        '{32'hAAAAAAAA, 1, 1, 0, 0, 0, 0, 0},
        '{32'h55555555, 1, 1, 1, 0, 0, 0, 0}
    };

    initial begin
        int items;
        int bsize;
        fraction_q = qet_pkg::RST_SELECT_FRACTION;
        factor_q = qet_pkg::RST_MEDIAN_FACTOR;
        cweight_q = qet_pkg::RST_CONSTANT_WEIGHT;
        oweight_q = qet_pkg::RST_OVERALL_WEIGHT;
        pat_count_q = qet_pkg::RST_PATTERN_COUNT;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i])
            send(directed[i].energy, directed[i].energy_valid, directed[i].targets_new,
                 directed[i].last, directed[i].typed,
                 '{directed[i].threshold, directed[i].used_count, directed[i].fallback});
        end_stream();

        // saturation and pattern count extremes
        write_reg(qet_pkg::REG_OVERALL_WEIGHT, 32'hFFFF);
        write_reg(qet_pkg::REG_MEDIAN_FACTOR, 32'hFFFF);
        write_reg(qet_pkg::REG_CONSTANT_WEIGHT, 32'h0);
        write_reg(qet_pkg::REG_SELECT_FRACTION, 32'hFFFF);
        write_reg(qet_pkg::REG_PATTERN_COUNT, 32'h0);
        send(32'hFFFFFFFF, 1, 1, 1, 1, '{32'hFFFFFFFF, 13'd1, 1'b0});
        send(32'h0, 1, 0, 1, 1, '{32'h0, 13'd0, 1'b1});
        end_stream();
        write_reg(qet_pkg::REG_PATTERN_COUNT, 32'h1F);
        send(32'h0, 0, 0, 1);
        end_stream();

        items = 0;
        while (items < 1600) begin
            write_reg(qet_pkg::REG_SELECT_FRACTION, rand_weight());
            write_reg(qet_pkg::REG_MEDIAN_FACTOR, rand_weight());
            write_reg(qet_pkg::REG_CONSTANT_WEIGHT, rand_weight());
            write_reg(qet_pkg::REG_OVERALL_WEIGHT, $urandom_range(0, 1) ? rand_weight()
                                                                        : $urandom_range(0, 1024));
            write_reg(qet_pkg::REG_PATTERN_COUNT, $urandom_range(0, 31));
            repeat ($urandom_range(2, 8)) begin
                bsize = $urandom_range(0, 7) == 0 ? $urandom_range(0, 2)
                                                   : $urandom_range(1, 20);
                for (int i = 0; i < bsize; i++) begin
                    send(rand_energy(), $urandom_range(0, 9) != 0,
                         $urandom_range(0, 9) != 0, 1'b0);
                    items++;
                end
                send(rand_energy(), $urandom_range(0, 1), $urandom_range(0, 1), 1'b1);
                items++;
                if (items > 1350) quiet = 1;
            end
            end_stream();
        end

        repeat (50) @(posedge aclk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
